// ===== src/obr_pkg.sv =====
// ----------------------------------------------------------------------------
// obr_pkg
// Shared types and constants for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned SIZE_RESET = 1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  // one access to the byte store from the request logic
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== src/obr_store.sv =====
// ----------------------------------------------------------------------------
// obr_store
// Byte store with a registered read and a zeroing sweep.
// ----------------------------------------------------------------------------
module obr_store
  import obr_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mem_ctl_t                    ctl,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic [BYTE_W-1:0]           wdata,
  input  logic                        sweep_start,
  input  logic [SIZE_W-1:0]           sweep_len,
  output logic [BYTE_W-1:0]           rdata,
  output logic                        sweep_busy
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic              busy_r, busy_nxt;
  logic [AW-1:0]     swp_addr_r, swp_addr_nxt;
  logic              swp_last;

  // last slot of the used region
  assign swp_last = (CW'(swp_addr_r) + CW'(1)) >= CW'(sweep_len);

  always_comb begin
    busy_nxt     = busy_r;
    swp_addr_nxt = swp_addr_r;
    if (sweep_start) begin
      busy_nxt     = 1'b1;
      swp_addr_nxt = '0;
    end else if (busy_r) begin
      if (swp_last) begin
        busy_nxt = 1'b0;
      end
      swp_addr_nxt = swp_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      swp_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      swp_addr_r <= swp_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[swp_addr_r] <= '0;
    end else if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata      = rdata_r;
  assign sweep_busy = busy_r;

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !(ctl.we || ctl.re))
    else $error("store access during clearing sweep");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !sweep_start |-> CW'(swp_addr_r) < CW'(sweep_len))
    else $error("sweep address beyond used region");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && swp_last && !sweep_start |=> !busy_r || $past(sweep_start))
    else $error("sweep did not end at last slot");

endmodule

// ===== src/overwriting_byte_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_core
// Byte ring buffer that overwrites its oldest data when full; serves write,
// read, peek and clear requests against one synchronous byte store.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                      handshake
//  in_*     slave      tuser: req_type; tdata: write_byte, distance tvalid/tready
//  out_*    master     tuser: read_valid, overwrote; tdata: byte, fill tvalid/tready
//  cfg_*    write      size_in_use                                  cfg_wr_en only
//
//  One request per cycle: pointers update at the input transfer, the store is
//  read on the same edge and its registered data forms the result in the next
//  cycle. Reset and every clear or size write start a zeroing sweep of the used
//  slots (1024 after reset at the default DEPTH); no input transfer is taken
//  during it. Apart from the sweep, the input stalls only while a result is
//  held by a stalled output.
//
module overwriting_byte_ring_buffer_core
  import obr_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // input requests
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [REQ_W-1:0]    in_tuser,   // [1:0] req_type
  input  logic [23:0]         in_tdata,   // [7:0] write_byte, [18:8] peek_distance, pad
  // results
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [1:0]          out_tuser,  // [0] read_valid, [1] overwrote
  output logic [23:0]         out_tdata,  // [7:0] read_byte, [18:8] fill_count, pad
  // configuration
  input  logic                cfg_wr_en,
  input  logic [SIZE_W-1:0]   cfg_wr_data // size_in_use
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [SIZE_W-1:0] EFF_RESET =
    (SIZE_RESET > DEPTH) ? SIZE_W'(DEPTH) : SIZE_W'(SIZE_RESET);

  // ring state
  logic [SIZE_W-1:0] eff_r, eff_nxt;        // effective size, 1..min(DEPTH,2047)
  logic [AW-1:0]     wi_r, wi_nxt;
  logic [AW-1:0]     ri_r, ri_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic              ov_r, ov_nxt;          // result waiting
  logic              use_mem_r, use_mem_nxt;
  logic              over_r, over_nxt;
  logic [SIZE_W-1:0] fill_r, fill_nxt;

  // request decode
  req_type_t         req;
  logic [BYTE_W-1:0] wbyte;
  logic [SIZE_W-1:0] peek_dist;
  logic              accept;
  logic              sweep_busy;
  logic              sweep_start;
  logic [BYTE_W-1:0] rdata;
  mem_ctl_t          mctl;
  logic [AW-1:0]     maddr;

  logic [CW-1:0]     wi_inc, ri_inc, pk_sum, pk_ix;
  logic [AW-1:0]     wi_step, ri_step;
  logic [SIZE_W-1:0] s_in;

  assign req       = req_type_t'(in_tuser);
  assign wbyte     = in_tdata[7:0];
  assign peek_dist = in_tdata[18:8];

  assign in_tready = !sweep_busy && (!ov_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // next slot with wrap at the effective size
  assign wi_inc  = CW'(wi_r) + CW'(1);
  assign ri_inc  = CW'(ri_r) + CW'(1);
  assign wi_step = (wi_inc >= CW'(eff_r)) ? '0 : AW'(wi_inc);
  assign ri_step = (ri_inc >= CW'(eff_r)) ? '0 : AW'(ri_inc);

  // peek slot: write index plus size minus distance, folded once
  assign pk_sum = CW'(wi_r) + CW'(eff_r) - CW'(peek_dist);
  assign pk_ix  = (pk_sum >= CW'(eff_r)) ? (pk_sum - CW'(eff_r)) : pk_sum;

  // size register: zero acts as one, above DEPTH acts as DEPTH
  assign s_in = cfg_wr_data;
  always_comb begin
    if (s_in == '0) begin
      eff_nxt = SIZE_W'(1);
    end else if (CW'(s_in) > DEPTH_C) begin
      eff_nxt = SIZE_W'(DEPTH_C);
    end else begin
      eff_nxt = s_in;
    end
  end

  always_comb begin
    wi_nxt      = wi_r;
    ri_nxt      = ri_r;
    cnt_nxt     = cnt_r;
    use_mem_nxt = use_mem_r;
    over_nxt    = over_r;
    fill_nxt    = fill_r;
    mctl        = '0;
    maddr       = wi_r;
    sweep_start = 1'b0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end

    if (cfg_wr_en) begin
      // re-initialise the ring for the new size
      wi_nxt      = '0;
      ri_nxt      = '0;
      cnt_nxt     = '0;
      sweep_start = 1'b1;
    end else if (accept) begin
      ov_nxt      = 1'b1;
      use_mem_nxt = 1'b0;
      over_nxt    = 1'b0;
      unique case (req)
        REQ_WRITE: begin
          mctl.we  = 1'b1;
          maddr    = wi_r;
          wi_nxt   = wi_step;
          over_nxt = (cnt_r >= eff_r);
          if (cnt_r < eff_r) begin
            cnt_nxt = cnt_r + SIZE_W'(1);
          end
          // full ring: oldest byte follows the write index
          if (CW'(cnt_r) + CW'(1) >= CW'(eff_r)) begin
            ri_nxt = wi_step;
          end
        end
        REQ_READ: begin
          if (cnt_r != '0) begin
            mctl.re     = 1'b1;
            maddr       = ri_r;
            use_mem_nxt = 1'b1;
            cnt_nxt     = cnt_r - SIZE_W'(1);
            ri_nxt      = ri_step;
          end
        end
        REQ_PEEK: begin
          if (peek_dist != '0 && peek_dist <= eff_r) begin
            mctl.re     = 1'b1;
            maddr       = AW'(pk_ix);
            use_mem_nxt = 1'b1;
          end
        end
        REQ_CLEAR: begin
          wi_nxt      = '0;
          ri_nxt      = '0;
          cnt_nxt     = '0;
          sweep_start = 1'b1;
        end
        default: begin
        end
      endcase
      fill_nxt = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= EFF_RESET;
      wi_r  <= '0;
      ri_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eff_r <= eff_nxt;
      end
      wi_r  <= wi_nxt;
      ri_r  <= ri_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    use_mem_r <= use_mem_nxt;
    over_r    <= over_nxt;
    fill_r    <= fill_nxt;
  end

  obr_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mctl),
    .addr       (maddr),
    .wdata      (wbyte),
    .sweep_start(sweep_start),
    .sweep_len  (eff_r),
    .rdata      (rdata),
    .sweep_busy (sweep_busy)
  );

  // byte is zero unless a read or peek was served
  assign out_tvalid = ov_r;
  assign out_tuser  = {over_r, use_mem_r};
  assign out_tdata  = {5'd0, fill_r, (use_mem_r ? rdata : {BYTE_W{1'b0}})};

  a_count_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= eff_r)
    else $error("fill count above ring size");

  a_windex_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(wi_r) < CW'(eff_r) && CW'(ri_r) < CW'(eff_r))
    else $error("ring index outside used slots");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == REQ_CLEAR |=> sweep_busy && !in_tready && fill_r == '0)
    else $error("clear did not start sweep");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(use_mem_r && over_r))
    else $error("read and overwrite flagged together");

endmodule
